>>> hw/rtl/radix_integer_token_parser_assert.svh
// Assertion macros for the token parser.
`ifndef RADIX_INTEGER_TOKEN_PARSER_ASSERT_SVH
`define RADIX_INTEGER_TOKEN_PARSER_ASSERT_SVH

`ifndef SYNTH
`define RIT_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
`define RIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RIT_ASSERT(lbl, clk, rstn, prop)
`define RIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/rit_pkg.sv
`timescale 1ns / 1ps

package rit_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int RADIX_W     = 6;
	localparam int STATUS_W    = 2;
	localparam int CH_W        = 8;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] DEC_BASE  = 6'd10;
	localparam logic [RADIX_W-1:0] LETTER_OFS = 6'd10;

	localparam logic [CH_W-1:0] CH_HASH  = 8'h23;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_0     = 8'h30;
	localparam logic [CH_W-1:0] CH_9     = 8'h39;
	localparam logic [CH_W-1:0] CH_UA    = 8'h41;
	localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CH_W-1:0] CH_LA    = 8'h61;
	localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_DEC   = 4'b0010,
		PH_RADIX = 4'b0100,
		PH_ERR   = 4'b1000
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_SYNTAX = 2'd1,
		ST_RANGE  = 2'd2
	} status_t;

endpackage

>>> hw/rtl/radix_integer_token_parser.sv
`timescale 1ns / 1ps
// A result is registered: the final request of a token is accepted into the input register,
// then passes through the digit multiply-add into the result register.
// Throughput: one character per cycle; the multiply-add by the radix sets the cycle.
// A final character waits in the input register while an earlier result is still held.
// Reset (arst_n low) clears the handshake flags and the token state at once; no clearing pass.

`include "radix_integer_token_parser_assert.svh"

module radix_integer_token_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rit_pkg::CH_W-1:0]         s_tdata,  // [7:0] ch
	input  logic                             s_tuser,  // [0] no_char
	input  logic                             s_tlast,  // last
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rit_pkg::VALUE_WIDTH-1:0]  m_tdata,  // [31:0] value
	output logic [rit_pkg::STATUS_W-1:0]     m_tuser   // [1:0] status
);
	import rit_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam logic [VW+3:0] SMAX = {5'd0, {(VW-1){1'b1}}};

	logic            valid_s1;
	logic [CH_W-1:0] ch_s1;
	logic            no_char_s1;
	logic            last_s1;

	phase_t               phase_q, phase_d;
	logic                 neg_q, neg_d;
	logic                 sign_q, sign_d;
	logic [VW-1:0]        acc_q, acc_d;
	logic [RADIX_W-1:0]   radix_q, radix_d;
	logic                 seen_q, seen_d;
	logic                 ovf_q, ovf_d;

	logic                 out_valid_q;
	logic [VW-1:0]        value_q;
	status_t              status_q;

	logic                 proceed;
	logic                 is_dec;
	logic                 is_lower;
	logic                 is_upper;
	logic [CH_W-1:0]      dec_ch;
	logic [CH_W-1:0]      let_ch;
	logic [RADIX_W-1:0]   dig;
	logic                 dig_ok;
	logic [VW+3:0]        dec_sum;
	logic [VW+RADIX_W-1:0] rad_prod;
	logic [VW-1:0]        rad_next;
	logic                 base_ok;
	logic [VW-1:0]        fin_value;
	status_t              fin_status;

	assign proceed  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || proceed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1      <= s_tdata;
			no_char_s1 <= s_tuser;
			last_s1    <= s_tlast;
		end
	end

	// character classes and digit value
	always_comb begin
		is_dec   = (ch_s1 >= CH_0) && (ch_s1 <= CH_9);
		is_lower = (ch_s1 >= CH_LA) && (ch_s1 <= CH_LZ);
		is_upper = (ch_s1 >= CH_UA) && (ch_s1 <= CH_UZ);
		dec_ch   = ch_s1 - CH_0;
		let_ch   = is_lower ? (ch_s1 - CH_LA) : (ch_s1 - CH_UA);
		if (is_dec) begin
			dig = dec_ch[RADIX_W-1:0];
		end else begin
			dig = let_ch[RADIX_W-1:0] + LETTER_OFS;
		end
		dig_ok   = (is_dec || is_lower || is_upper) && (dig < radix_q);
		dec_sum  = {4'd0, acc_q} * {{(VW-2){1'b0}}, DEC_BASE}
			+ {{(VW+4-RADIX_W){1'b0}}, dec_ch[RADIX_W-1:0]};
		rad_prod = {{RADIX_W{1'b0}}, acc_q} * {{VW{1'b0}}, radix_q};
		rad_next = rad_prod[VW-1:0] + {{(VW-RADIX_W){1'b0}}, dig};
		base_ok  = (acc_q >= {{(VW-RADIX_W){1'b0}}, RADIX_MIN})
			&& (acc_q <= {{(VW-RADIX_W){1'b0}}, RADIX_MAX});
	end

	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		sign_d  = sign_q;
		acc_d   = acc_q;
		radix_d = radix_q;
		seen_d  = seen_q;
		ovf_d   = ovf_q;
		if (!no_char_s1) begin
			unique case (phase_q)
				PH_START: begin
					if (ch_s1 == CH_MINUS) begin
						neg_d   = 1'b1;
						sign_d  = 1'b1;
						phase_d = PH_DEC;
					end else if (ch_s1 == CH_PLUS) begin
						sign_d  = 1'b1;
						phase_d = PH_DEC;
					end else if (is_dec) begin
						if (dec_sum > SMAX) begin
							ovf_d = 1'b1;
						end else begin
							acc_d = dec_sum[VW-1:0];
						end
						seen_d  = 1'b1;
						phase_d = PH_DEC;
					end else begin
						phase_d = PH_ERR;
					end
				end
				PH_DEC: begin
					if (is_dec) begin
						if (!ovf_q) begin
							if (dec_sum > SMAX) begin
								ovf_d = 1'b1;
							end else begin
								acc_d = dec_sum[VW-1:0];
							end
						end
						seen_d = 1'b1;
					end else if (ch_s1 == CH_HASH && !sign_q && seen_q && !ovf_q && base_ok) begin
						radix_d = acc_q[RADIX_W-1:0];
						acc_d   = '0;
						seen_d  = 1'b0;
						phase_d = PH_RADIX;
					end else begin
						phase_d = PH_ERR;
					end
				end
				PH_RADIX: begin
					if (dig_ok) begin
						acc_d  = rad_next;
						seen_d = 1'b1;
					end else begin
						phase_d = PH_ERR;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		fin_value  = '0;
		fin_status = ST_SYNTAX;
		if (phase_d == PH_DEC && seen_d) begin
			if (ovf_d) begin
				fin_status = ST_RANGE;
			end else begin
				fin_status = ST_OK;
				fin_value  = neg_d ? ('0 - acc_d) : acc_d;
			end
		end else if (phase_d == PH_RADIX && seen_d) begin
			fin_status = ST_OK;
			fin_value  = acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			sign_q  <= 1'b0;
			acc_q   <= '0;
			radix_q <= DEC_BASE;
			seen_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (proceed) begin
			if (last_s1) begin
				phase_q <= PH_START;
				neg_q   <= 1'b0;
				sign_q  <= 1'b0;
				acc_q   <= '0;
				radix_q <= DEC_BASE;
				seen_q  <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				sign_q  <= sign_d;
				acc_q   <= acc_d;
				radix_q <= radix_d;
				seen_q  <= seen_d;
				ovf_q   <= ovf_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proceed && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && last_s1) begin
			value_q  <= fin_value;
			status_q <= fin_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = value_q;
	assign m_tuser  = status_q;

	`RIT_ASSERT(a_phase_onehot, clk, arst_n, $onehot(phase_q))
	`RIT_ASSERT(a_radix_range, clk, arst_n, (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX))
	`RIT_ASSERT(a_stall_cause, clk, arst_n, s_tready || (valid_s1 && last_s1 && out_valid_q))
	`RIT_ASSERT(a_err_zero, clk, arst_n, !out_valid_q || status_q == ST_OK || value_q == '0)
	`RIT_ASSERT_NEXT(a_token_clear, clk, arst_n, proceed && last_s1, phase_q == PH_START && acc_q == '0 && out_valid_q)
	`RIT_ASSERT(a_dec_bound, clk, arst_n, (phase_q != PH_DEC || {4'd0, acc_q} <= SMAX))

endmodule

>>> sim/radix_integer_token_parser_check.sv
`timescale 1ns / 1ps

module radix_integer_token_parser_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [rit_pkg::CH_W-1:0]        s_tdata,  // [7:0] ch
	input  logic                            s_tuser,  // [0] no_char
	input  logic                            s_tlast,  // last
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [rit_pkg::VALUE_WIDTH-1:0] m_tdata,  // [31:0] value
	input  logic [rit_pkg::STATUS_W-1:0]    m_tuser,  // [1:0] status
	output int                              errors,
	output int                              due_count
);
	import rit_pkg::*;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		status_t                status;
	} token_result_t;

	localparam longint unsigned SIGNED_MAX = (64'd1 << (VALUE_WIDTH - 1)) - 1;

	phase_t                 phase;
	logic                   negative;
	logic                   has_sign;
	logic                   digit_seen;
	logic                   overflowed;
	logic [VALUE_WIDTH-1:0] acc;
	int unsigned            base;
	token_result_t          results_due[$];

	function automatic void clear_token();
		phase      = PH_START;
		negative   = 1'b0;
		has_sign   = 1'b0;
		digit_seen = 1'b0;
		overflowed = 1'b0;
		acc        = '0;
		base       = DEC_BASE;
	endfunction

	// -1 when c is not a digit of base b
	function automatic int digit_value(logic [CH_W-1:0] c, int unsigned b);
		int unsigned d;
		if (c >= CH_0 && c <= CH_9)
			d = c - CH_0;
		else if (c >= CH_LA && c <= CH_LZ)
			d = c - CH_LA + LETTER_OFS;
		else if (c >= CH_UA && c <= CH_UZ)
			d = c - CH_UA + LETTER_OFS;
		else
			return -1;
		return (d < b) ? int'(d) : -1;
	endfunction

	// checked decimal accumulate: flags overflow and stops, never wraps
	function automatic void add_decimal(int unsigned d);
		if (!overflowed) begin
			if (64'(acc) > (SIGNED_MAX - d) / 10)
				overflowed = 1'b1;
			else
				acc = VALUE_WIDTH'(64'(acc) * 10 + d);
		end
	endfunction

	function automatic void scan_char(logic [CH_W-1:0] c);
		int d;
		d = digit_value(c, (phase == PH_RADIX) ? base : DEC_BASE);
		case (phase)
			PH_START: begin
				if (c == CH_MINUS) begin
					negative = 1'b1;
					has_sign = 1'b1;
					phase    = PH_DEC;
				end else if (c == CH_PLUS) begin
					has_sign = 1'b1;
					phase    = PH_DEC;
				end else if (d >= 0) begin
					add_decimal(d);
					digit_seen = 1'b1;
					phase      = PH_DEC;
				end else begin
					phase = PH_ERR;
				end
			end
			PH_DEC: begin
				if (d >= 0) begin
					add_decimal(d);
					digit_seen = 1'b1;
				end else if (c == CH_HASH && !has_sign && digit_seen && !overflowed &&
						acc >= RADIX_MIN && acc <= RADIX_MAX) begin
					base       = acc;
					acc        = '0;
					digit_seen = 1'b0;
					phase      = PH_RADIX;
				end else begin
					phase = PH_ERR;
				end
			end
			PH_RADIX: begin
				if (d < 0) begin
					phase = PH_ERR;
				end else begin
					acc        = VALUE_WIDTH'(64'(acc) * base + d);
					digit_seen = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic token_result_t close_token();
		token_result_t r;
		r.value = '0;
		if (phase == PH_DEC && digit_seen) begin
			if (overflowed) begin
				r.status = ST_RANGE;
			end else begin
				r.status = ST_OK;
				r.value  = negative ? -acc : acc;
			end
		end else if (phase == PH_RADIX && digit_seen) begin
			r.status = ST_OK;
			r.value  = acc;
		end else begin
			r.status = ST_SYNTAX;
		end
		clear_token();
		return r;
	endfunction

	function automatic void note_failure(string msg);
		errors++;
		if (errors <= 10)
			$display("%0t ns mismatch: %s", $time, msg);
	endfunction

	initial begin
		errors    = 0;
		due_count = 0;
		clear_token();
	end

	always @(posedge clk) begin : watch
		token_result_t want;
		if (arst_n) begin
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				if (results_due.size() == 0) begin
					note_failure($sformatf("result value=%h st=%0d with nothing due",
						m_tdata, m_tuser));
				end else begin
					want = results_due.pop_front();
					if (m_tdata !== want.value || m_tuser !== want.status)
						note_failure($sformatf("got value=%h st=%0d, want value=%h st=%0d",
							m_tdata, m_tuser, want.value, want.status));
				end
			end
			if (s_tvalid === 1'b1 && s_tready === 1'b1) begin
				if (!s_tuser)
					scan_char(s_tdata);
				if (s_tlast)
					results_due.push_back(close_token());
			end
			due_count = results_due.size();
		end
	end

endmodule

>>> sim/radix_integer_token_parser_test.sv
`timescale 1ns / 1ps

module radix_integer_token_parser_test;
	import rit_pkg::*;

	typedef logic [CH_W:0] token_item_t;  // {no_char, ch}

	localparam longint unsigned SIGNED_MAX = (64'd1 << (VALUE_WIDTH - 1)) - 1;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [CH_W-1:0]        s_tdata  = '0;
	logic                   s_tuser  = 1'b0;
	logic                   s_tlast  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [VALUE_WIDTH-1:0] m_tdata;
	logic [STATUS_W-1:0]    m_tuser;
	int                     errors;
	int                     due_count;

	int          send_idle_pct = 25;
	int          recv_idle_pct = 79;
	int          stall_asks    = 0;
	int          chars_sent    = 0;
	token_item_t tok[$];

	radix_integer_token_parser dut (.*);

	radix_integer_token_parser_check parse_check (.*);

	always #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// receiver: random ready, plus long hold-offs on request
	initial begin
		int stalls_done;
		stalls_done = 0;
		forever begin
			@(negedge clk);
			if (stall_asks != stalls_done) begin
				stalls_done++;
				m_tready = 1'b0;
				repeat (400) @(negedge clk);
			end
			m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic void put_ch(logic [CH_W-1:0] c);
		tok.push_back({1'b0, c});
	endfunction

	function automatic void put_str(string s);
		foreach (s[i])
			put_ch(s[i]);
	endfunction

	function automatic void put_digits(int n);
		repeat (n)
			put_ch(CH_W'(CH_0 + $urandom_range(0, 9)));
	endfunction

	function automatic void put_sign();
		put_ch($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
	endfunction

	function automatic logic [CH_W-1:0] digit_char(int d);
		if (d < 10)
			return CH_W'(CH_0 + d);
		return CH_W'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10);
	endfunction

	function automatic void build_decimal();
		int pick;
		if ($urandom_range(0, 2) != 0)
			put_sign();
		pick = $urandom_range(0, 9);
		if (pick < 6)
			put_digits($urandom_range(1, 5));
		else if (pick < 8)
			put_str($sformatf("%0d", SIGNED_MAX - 2 + $urandom_range(0, 5)));
		else
			put_digits($urandom_range(9, 14));
	endfunction

	function automatic void build_radix(bit with_digits);
		int b;
		int n;
		b = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? RADIX_MAX : RADIX_MIN)
			: $urandom_range(RADIX_MIN, RADIX_MAX);
		if ($urandom_range(0, 9) == 0)
			put_ch(CH_0);
		put_str($sformatf("%0d", b));
		put_ch(CH_HASH);
		if (with_digits) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
			repeat (n)
				put_ch(digit_char($urandom_range(0, b - 1)));
		end
	endfunction

	function automatic void corrupt_one();
		int at;
		at = $urandom_range(0, tok.size() - 1);
		tok[at] = {1'b0, CH_W'($urandom_range(0, 255))};
	endfunction

	function automatic void build_broken();
		case ($urandom_range(0, 7))
			0: begin
				build_decimal();
				corrupt_one();
			end
			1: begin
				build_radix(1'b1);
				corrupt_one();
			end
			2: begin
				put_sign();
				build_radix(1'b1);
			end
			3: begin
				case ($urandom_range(0, 2))
					0: put_str($sformatf("%0d", $urandom_range(0, 1)));
					1: put_str($sformatf("%0d", $urandom_range(37, 99)));
					default: put_digits($urandom_range(11, 14));
				endcase
				put_ch(CH_HASH);
				if ($urandom_range(0, 1))
					put_ch(digit_char($urandom_range(0, 1)));
			end
			4: build_radix(1'b0);
			5: begin
				build_radix(1'b1);
				put_ch(CH_HASH);
			end
			6: put_sign();
			default: begin
				build_decimal();
				put_ch(CH_HASH);
			end
		endcase
	endfunction

	function automatic void build_random_token();
		int pick;
		int at;
		tok.delete();
		pick = $urandom_range(0, 99);
		if (pick < 3)
			;  // empty token
		else if (pick < 38)
			build_decimal();
		else if (pick < 73)
			build_radix(1'b1);
		else if (pick < 88)
			build_broken();
		else
			repeat ($urandom_range(1, 6))
				put_ch(CH_W'($urandom_range(0, 255)));
		if (tok.size() == 0 || $urandom_range(0, 9) == 0) begin
			at = $urandom_range(0, tok.size());
			if (at == tok.size())
				tok.push_back({1'b1, CH_W'($urandom_range(0, 255))});
			else
				tok.insert(at, {1'b1, CH_W'($urandom_range(0, 255))});
		end
	endfunction

	// entered and left at a falling edge
	task automatic send_item(logic nc, logic [CH_W-1:0] c, logic fin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			s_tdata  = CH_W'($urandom_range(0, 255));
			s_tuser  = 1'($urandom_range(0, 1));
			s_tlast  = 1'($urandom_range(0, 1));
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = c;
		s_tuser  = nc;
		s_tlast  = fin;
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_token();
		foreach (tok[i]) begin
			send_item(tok[i][CH_W], tok[i][CH_W-1:0], i == tok.size() - 1);
			if (!tok[i][CH_W])
				chars_sent++;
		end
	endtask

	task automatic send_text(string s);
		tok.delete();
		put_str(s);
		send_token();
	endtask

	task automatic wait_for_results();
		s_tvalid = 1'b0;
		while (due_count != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tok.delete();
		tok.push_back({1'b1, 8'h00});
		send_token();
		send_text("+");
		send_text("-0");
		send_text("36#zZ");
		send_text("2#1");
		send_text("+2#1");
		send_text("37#1");
		send_text("16#");
		send_text("8#9");
		tok.delete();
		put_ch(8'hFF);
		send_token();

		while (chars_sent < 1800) begin
			if (send_idle_pct == 25 && chars_sent >= 600) begin
				wait_for_results();
				send_idle_pct = 79;
				recv_idle_pct = 25;
				stall_asks++;
			end else if (send_idle_pct == 79 && chars_sent >= 1200) begin
				wait_for_results();
				send_idle_pct = 0;
				recv_idle_pct = 0;
				stall_asks++;
			end
			build_random_token();
			send_token();
		end

		wait_for_results();
		repeat (20) @(negedge clk);
		if (errors == 0 && due_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
